FILE: rtl/wcs_pkg.sv
// Shared types, register indexes, reset values and constants of the washer cycle sequencer.
`default_nettype none

package wcs_pkg;

    // Sequencer state, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_WASH  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_SPIN  = 5'b10000
    } t_phase;

    // Phase codes as seen on the result port
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FILL  = 3'd1;
    localparam logic [2:0] PH_WASH  = 3'd2;
    localparam logic [2:0] PH_DRAIN = 3'd3;
    localparam logic [2:0] PH_SPIN  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_MS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAIN_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WASH_STEPS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPEED = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_FILL_MS     = 16'd2000;
    localparam logic [15:0] RST_DRAIN_MS    = 16'd2000;
    localparam logic [15:0] RST_STEP_MS     = 16'd1000;
    localparam logic [7:0]  RST_WASH_STEPS  = 8'd11;
    localparam logic [7:0]  RST_SPIN_STEPS  = 8'd4;
    localparam logic [15:0] RST_BLINK_HALF  = 16'd1000;
    localparam logic [7:0]  RST_START_SPEED = 8'd63;

    // x / 5 == (x * 0xCCCD) >> 18, exact for every x below 2**16
    localparam logic [16:0] DIV5_MUL   = 17'h0CCCD;
    localparam int          DIV5_SHIFT = 18;

    // LED pair codes: bit 0 first LED, bit 1 second LED
    localparam logic [1:0] LED_FIRST  = 2'b01;
    localparam logic [1:0] LED_SECOND = 2'b10;

endpackage

`default_nettype wire

FILE: rtl/washer_cycle_sequencer.sv
// Top level of the washer cycle sequencer: tick input stage, cycle state, blink and result port.
`default_nettype none

// One input word is one 1 ms tick carrying the two button levels; one result word comes back
// for each tick with the relay drives, motor speed, LED pair and phase as they stand after that
// tick. A word sits in the input register, and the next-state logic (a tick counter compare,
// the speed step with saturation, a one-multiply divide-by-five increase in wash and doubling
// in spin, and the blink counter) writes the state registers, which also serve as the result
// register. A word is taken every clock cycle while input stall is low. Input stall rises
// only when the input register is full and the result is held by output stall. Configuration
// must be written while the block is idle (not enforced) and takes effect on the next tick.
module washer_cycle_sequencer #(
    parameter int SPEED_WIDTH = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [wcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wcs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // tick input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_btn_wash,
    input  wire logic                           i_btn_spin,
    // result channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_relay_fill,
    output logic                                o_relay_drain,
    output logic [SPEED_WIDTH-1:0]              o_motor_speed,
    output logic                                o_led_first,
    output logic                                o_led_second,
    output logic [2:0]                          o_phase
);

    // working width for speed arithmetic: covers 8-bit start speed and one carry bit
    localparam int WW = SPEED_WIDTH + 9;
    localparam logic [WW-1:0] SPEED_MAX = WW'((1 << SPEED_WIDTH) - 1);
    localparam int PROD_W = SPEED_WIDTH + 17;

    // configuration registers
    logic [15:0] r_fill_ms;
    logic [15:0] r_drain_ms;
    logic [15:0] r_step_ms;
    logic [7:0]  r_wash_steps;
    logic [7:0]  r_spin_steps;
    logic [15:0] r_blink_half;
    logic [7:0]  r_start_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_ms     <= wcs_pkg::RST_FILL_MS;
            r_drain_ms    <= wcs_pkg::RST_DRAIN_MS;
            r_step_ms     <= wcs_pkg::RST_STEP_MS;
            r_wash_steps  <= wcs_pkg::RST_WASH_STEPS;
            r_spin_steps  <= wcs_pkg::RST_SPIN_STEPS;
            r_blink_half  <= wcs_pkg::RST_BLINK_HALF;
            r_start_speed <= wcs_pkg::RST_START_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wcs_pkg::REG_FILL_MS:     r_fill_ms     <= i_cfg_data;
                wcs_pkg::REG_DRAIN_MS:    r_drain_ms    <= i_cfg_data;
                wcs_pkg::REG_STEP_MS:     r_step_ms     <= i_cfg_data;
                wcs_pkg::REG_WASH_STEPS:  r_wash_steps  <= i_cfg_data[7:0];
                wcs_pkg::REG_SPIN_STEPS:  r_spin_steps  <= i_cfg_data[7:0];
                wcs_pkg::REG_BLINK_HALF:  r_blink_half  <= i_cfg_data;
                wcs_pkg::REG_START_SPEED: r_start_speed <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register and handshake
    logic r_in_valid;
    logic r_in_wash;
    logic r_in_spin;
    logic r_out_valid;
    logic w_move;

    assign w_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_wash <= i_btn_wash;
            r_in_spin <= i_btn_spin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // cycle state, doubles as the result register
    wcs_pkg::t_phase         r_phase,      n_phase;
    logic [15:0]             r_tick,       n_tick;
    logic [7:0]              r_step,       n_step;
    logic [SPEED_WIDTH-1:0]  r_speed,      n_speed;
    logic                    r_blink_on,   n_blink_on;
    logic [16:0]             r_blink_cnt,  n_blink_cnt;
    logic [1:0]              r_led_pair,   n_led_pair;

    // speed step candidates
    logic [PROD_W-1:0]       w_prod;
    logic [SPEED_WIDTH-2:0]  w_fifth;
    logic [WW-1:0]           w_start_ext;
    logic [WW-1:0]           w_start_sat;
    logic [WW-1:0]           w_cur_ext;
    logic [WW-1:0]           w_raw_step;
    logic [WW-1:0]           w_step_sat;
    logic                    w_is_spin;

    assign w_is_spin   = (r_phase == wcs_pkg::ST_SPIN);
    assign w_prod      = {{(PROD_W-SPEED_WIDTH){1'b0}}, r_speed} *
                         {{(PROD_W-17){1'b0}}, wcs_pkg::DIV5_MUL};
    assign w_fifth     = w_prod[PROD_W-1:wcs_pkg::DIV5_SHIFT];
    assign w_start_ext = {{(WW-8){1'b0}}, r_start_speed};
    assign w_start_sat = (w_start_ext > SPEED_MAX) ? SPEED_MAX : w_start_ext;
    assign w_cur_ext   = {{(WW-SPEED_WIDTH){1'b0}}, r_speed};

    always_comb begin
        if (r_step == 8'd0) begin
            w_raw_step = w_start_ext;
        end else if (w_is_spin) begin
            w_raw_step = {w_cur_ext[WW-2:0], 1'b0};
        end else begin
            w_raw_step = w_cur_ext + {{(WW-SPEED_WIDTH+1){1'b0}}, w_fifth};
        end
        w_step_sat = (w_raw_step > SPEED_MAX) ? SPEED_MAX : w_raw_step;
    end

    // tick counter and phase limits
    logic [15:0] w_tick_inc;
    logic [15:0] w_limit;
    logic        w_elapsed;
    logic [7:0]  w_steps;

    assign w_tick_inc = r_tick + 16'd1;
    assign w_steps    = w_is_spin ? r_spin_steps : r_wash_steps;

    always_comb begin
        unique case (r_phase)
            wcs_pkg::ST_FILL:  w_limit = r_fill_ms;
            wcs_pkg::ST_DRAIN: w_limit = r_drain_ms;
            default:           w_limit = r_step_ms;
        endcase
    end

    assign w_elapsed = (w_tick_inc >= w_limit);

    // sequencer next state
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_step     = r_step;
        n_speed    = r_speed;
        n_blink_on = r_blink_on;
        unique case (r_phase)
            wcs_pkg::ST_FILL, wcs_pkg::ST_DRAIN: begin
                if (w_elapsed) begin
                    // enter motor phase and apply its first step now
                    n_phase = (r_phase == wcs_pkg::ST_FILL) ? wcs_pkg::ST_WASH
                                                            : wcs_pkg::ST_SPIN;
                    n_tick  = 16'd0;
                    n_step  = 8'd1;
                    n_speed = w_start_sat[SPEED_WIDTH-1:0];
                end else begin
                    n_tick = w_tick_inc;
                end
            end
            wcs_pkg::ST_WASH, wcs_pkg::ST_SPIN: begin
                if (!w_elapsed) begin
                    n_tick = w_tick_inc;
                end else if (r_step >= w_steps) begin
                    // motor phase done
                    n_tick  = 16'd0;
                    n_step  = 8'd0;
                    n_speed = '0;
                    if (w_is_spin) begin
                        n_phase    = wcs_pkg::ST_IDLE;
                        n_blink_on = 1'b1;
                    end else begin
                        n_phase = wcs_pkg::ST_DRAIN;
                    end
                end else begin
                    n_tick  = 16'd0;
                    n_step  = r_step + 8'd1;
                    n_speed = w_step_sat[SPEED_WIDTH-1:0];
                end
            end
            default: begin
                // idle; wash has priority over spin
                n_phase = wcs_pkg::ST_IDLE;
                if (r_in_wash) begin
                    n_phase = wcs_pkg::ST_FILL;
                    n_tick  = 16'd0;
                end else if (r_in_spin) begin
                    n_phase = wcs_pkg::ST_DRAIN;
                    n_tick  = 16'd0;
                end
            end
        endcase
    end

    // blink process, runs after the sequencer on the same tick
    logic [16:0] w_blink_base;

    always_comb begin
        n_blink_cnt  = r_blink_cnt;
        n_led_pair   = r_led_pair;
        w_blink_base = (r_blink_cnt >= {r_blink_half, 1'b0}) ? 17'd0 : r_blink_cnt;
        if (n_blink_on) begin
            if (w_blink_base == 17'd0) begin
                n_led_pair = wcs_pkg::LED_SECOND;
            end
            if (w_blink_base == {1'b0, r_blink_half}) begin
                n_led_pair = wcs_pkg::LED_FIRST;
            end
            n_blink_cnt = w_blink_base + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wcs_pkg::ST_IDLE;
            r_tick      <= 16'd0;
            r_step      <= 8'd0;
            r_speed     <= '0;
            r_blink_on  <= 1'b0;
            r_blink_cnt <= 17'd0;
            r_led_pair  <= 2'b00;
        end else if (w_move) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_step      <= n_step;
            r_speed     <= n_speed;
            r_blink_on  <= n_blink_on;
            r_blink_cnt <= n_blink_cnt;
            r_led_pair  <= n_led_pair;
        end
    end

    // result word
    assign o_out_valid   = r_out_valid;
    assign o_relay_fill  = (r_phase == wcs_pkg::ST_FILL);
    assign o_relay_drain = (r_phase == wcs_pkg::ST_DRAIN);
    assign o_motor_speed = r_speed;
    assign o_led_first   = r_led_pair[0];
    assign o_led_second  = r_led_pair[1];

    always_comb begin
        unique case (r_phase)
            wcs_pkg::ST_FILL:  o_phase = wcs_pkg::PH_FILL;
            wcs_pkg::ST_WASH:  o_phase = wcs_pkg::PH_WASH;
            wcs_pkg::ST_DRAIN: o_phase = wcs_pkg::PH_DRAIN;
            wcs_pkg::ST_SPIN:  o_phase = wcs_pkg::PH_SPIN;
            default:           o_phase = wcs_pkg::PH_IDLE;
        endcase
    end

    // checks
    a_speed_only_in_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_speed != '0) |-> (r_phase == wcs_pkg::ST_WASH || r_phase == wcs_pkg::ST_SPIN))
        else $error("motor speed nonzero outside a motor phase");

    a_blink_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_on |=> r_blink_on)
        else $error("blink dropped without reset");

    a_leds_dark_before_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_blink_on |-> (r_led_pair == 2'b00))
        else $error("LED lit before blinking started");

    a_state_holds_without_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> ($stable(r_phase) && $stable(r_speed) && $stable(r_blink_cnt)))
        else $error("cycle state changed without a tick word");

    a_stall_needs_full_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire
